@@ sv/matrix_chain_order_dp_top_macros.svh @@
`ifndef MATRIX_CHAIN_ORDER_DP_TOP_MACROS_SVH
`define MATRIX_CHAIN_ORDER_DP_TOP_MACROS_SVH

// Both macros expect signals named clock and reset in the scope where they are used.

`define MCODP_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mcodp check failed");

`define MCODP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mcodp check failed");

`endif

@@ sv/mcodp_pkg.sv @@
`default_nettype none

package mcodp_pkg;

   localparam int unsigned MAX_MATRICES_DEF = 16;
   localparam int unsigned DIM_W = 16;
   localparam int unsigned COST_W = 64;
   localparam int unsigned OUT_IDX_W = 5;
   localparam logic [COST_W-1:0] COST_MAX = '1;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_INIT,
      ST_STEP,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_ends;
   } dim_cmd_type;

   typedef struct packed {
      logic init;
      logic issue;
      logic last;
   } step_cmd_type;

endpackage

`default_nettype wire

@@ sv/mcodp_dims.sv @@
`default_nettype none

module mcodp_dims
   import mcodp_pkg::*;
#(
   parameter int unsigned MAX_MATRICES = MAX_MATRICES_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire dim_cmd_type                             dcmd,
   input  wire logic [$clog2(MAX_MATRICES + 1)-1:0]     wr_addr,
   input  wire logic [DIM_W-1:0]                        wr_data,
   input  wire logic [$clog2(MAX_MATRICES + 1)-1:0]     rd_a_addr,
   input  wire logic [$clog2(MAX_MATRICES + 1)-1:0]     rd_b_addr,
   output logic      [DIM_W-1:0]                        pk,
   output logic      [DIM_W-1:0]                        pi,
   output logic      [DIM_W-1:0]                        pj
);

   localparam int unsigned DIM_DEPTH = MAX_MATRICES + 1;

   logic [DIM_W-1:0] dim_mem [DIM_DEPTH];
   logic [DIM_W-1:0] rd_a_ff;
   logic [DIM_W-1:0] rd_b_ff;
   logic [DIM_W-1:0] pi_ff;
   logic [DIM_W-1:0] pj_ff;
   logic             ends_ff;

   always_ff @(posedge clock) begin
      if (dcmd.wr_en) begin
         dim_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= dim_mem[rd_a_addr];
      rd_b_ff <= dim_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ends_ff <= 1'b0;
      end else begin
         ends_ff <= dcmd.rd_ends;
      end
   end

   // The outer dimensions of a cell are held for the whole split loop.
   always_ff @(posedge clock) begin
      if (ends_ff) begin
         pi_ff <= rd_a_ff;
         pj_ff <= rd_b_ff;
      end
   end

   assign pk = rd_a_ff;
   assign pi = pi_ff;
   assign pj = pj_ff;

endmodule

`default_nettype wire

@@ sv/mcodp_cell.sv @@
`default_nettype none

module mcodp_cell
   import mcodp_pkg::*;
#(
   parameter int unsigned MAX_MATRICES = MAX_MATRICES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire step_cmd_type                        scmd,
   input  wire logic [$clog2(MAX_MATRICES)-1:0]     i0,
   input  wire logic [$clog2(MAX_MATRICES)-1:0]     j0,
   input  wire logic [$clog2(MAX_MATRICES)-1:0]     k0,
   input  wire logic [DIM_W-1:0]                    pi,
   input  wire logic [DIM_W-1:0]                    pk,
   input  wire logic [DIM_W-1:0]                    pj,
   output logic                                     done,
   output logic      [COST_W-1:0]                   best_cost,
   output logic      [$clog2(MAX_MATRICES)-1:0]     best_k
);

   localparam int unsigned IDX_W = $clog2(MAX_MATRICES);
   localparam int unsigned TAB_DEPTH = MAX_MATRICES * MAX_MATRICES;
   localparam int unsigned TAB_AW = $clog2(TAB_DEPTH);
   localparam int unsigned PROD1_W = 2 * DIM_W;
   localparam int unsigned PROD2_W = 3 * DIM_W;

   function automatic logic [TAB_AW-1:0] tab_addr(input logic [IDX_W-1:0] row,
                                                  input logic [IDX_W-1:0] col);
      return TAB_AW'(row) * TAB_AW'(MAX_MATRICES) + TAB_AW'(col);
   endfunction

   function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COST_W] ? COST_MAX : s[COST_W-1:0];
   endfunction

   logic [COST_W-1:0]  cost_mem [TAB_DEPTH];
   logic [COST_W-1:0]  rd_l_ff;
   logic [COST_W-1:0]  rd_r_ff;
   logic [TAB_AW-1:0]  rd_l_addr;
   logic [TAB_AW-1:0]  rd_r_addr;
   logic [TAB_AW-1:0]  wr_addr;
   logic               wr_en;
   logic [IDX_W-1:0]   k_next;

   logic               s1_vld_ff;
   logic               s1_last_ff;
   logic [IDX_W-1:0]   s1_k_ff;
   logic               s1_ldiag_ff;
   logic               s1_rdiag_ff;

   logic               s2_vld_ff;
   logic               s2_last_ff;
   logic [IDX_W-1:0]   s2_k_ff;
   logic [COST_W-1:0]  s2_sum_ff;
   logic [PROD1_W-1:0] s2_prod_ff;

   logic               s3_vld_ff;
   logic               s3_last_ff;
   logic [IDX_W-1:0]   s3_k_ff;
   logic [COST_W-1:0]  s3_sum_ff;
   logic [PROD2_W-1:0] s3_prod_ff;

   logic               s4_vld_ff;
   logic               s4_last_ff;
   logic [IDX_W-1:0]   s4_k_ff;
   logic [COST_W-1:0]  s4_cand_ff;

   logic               done_ff;
   logic [COST_W-1:0]  best_ff;
   logic [COST_W-1:0]  best_in;
   logic [IDX_W-1:0]   best_k_ff;
   logic [IDX_W-1:0]   best_k_in;

   logic [COST_W-1:0]  lval;
   logic [COST_W-1:0]  rval;
   logic [COST_W-1:0]  s2_sum_in;
   logic [PROD1_W-1:0] s2_prod_in;
   logic [PROD2_W-1:0] s3_prod_in;
   logic [COST_W-1:0]  s4_cand_in;

   assign k_next    = k0 + IDX_W'(1);
   assign rd_l_addr = tab_addr(i0, k0);
   assign rd_r_addr = tab_addr(k_next, j0);
   assign wr_addr   = tab_addr(i0, j0);
   assign wr_en     = s4_vld_ff & s4_last_ff;

   // Each cell is written once, after its last split; the controller drains the
   // pipeline before the next cell reads, so no read can meet a pending write.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cost_mem[wr_addr] <= best_in;
      end
      rd_l_ff <= cost_mem[rd_l_addr];
      rd_r_ff <= cost_mem[rd_r_addr];
   end

   // Single-matrix subchains cost nothing and are never stored.
   assign lval       = s1_ldiag_ff ? '0 : rd_l_ff;
   assign rval       = s1_rdiag_ff ? '0 : rd_r_ff;
   assign s2_sum_in  = sat_add(lval, rval);
   assign s2_prod_in = PROD1_W'(pi) * PROD1_W'(pk);
   assign s3_prod_in = PROD2_W'(s2_prod_ff) * PROD2_W'(pj);
   assign s4_cand_in = sat_add(s3_sum_ff, COST_W'(s3_prod_ff));

   always_comb begin
      best_in   = best_ff;
      best_k_in = best_k_ff;
      if (scmd.init) begin
         best_in   = COST_MAX;
         best_k_in = i0 + IDX_W'(1);
      end else if (s4_vld_ff && (s4_cand_ff < best_ff)) begin
         best_in   = s4_cand_ff;
         best_k_in = s4_k_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         s1_vld_ff <= scmd.issue;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         done_ff   <= wr_en;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff  <= scmd.last;
      s1_k_ff     <= k_next;
      s1_ldiag_ff <= (k0 == i0);
      s1_rdiag_ff <= (k_next == j0);

      s2_last_ff  <= s1_last_ff;
      s2_k_ff     <= s1_k_ff;
      s2_sum_ff   <= s2_sum_in;
      s2_prod_ff  <= s2_prod_in;

      s3_last_ff  <= s2_last_ff;
      s3_k_ff     <= s2_k_ff;
      s3_sum_ff   <= s2_sum_ff;
      s3_prod_ff  <= s3_prod_in;

      s4_last_ff  <= s3_last_ff;
      s4_k_ff     <= s3_k_ff;
      s4_cand_ff  <= s4_cand_in;

      best_ff     <= best_in;
      best_k_ff   <= best_k_in;
   end

   assign done      = done_ff;
   assign best_cost = best_ff;
   assign best_k    = best_k_ff;

endmodule

`default_nettype wire

@@ sv/mcodp_ctrl.sv @@
`default_nettype none

module mcodp_ctrl
   import mcodp_pkg::*;
#(
   parameter int unsigned MAX_MATRICES = MAX_MATRICES_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    start,
   output logic                                         busy,
   input  wire logic [DIM_W-1:0]                        req_dim_value,
   input  wire logic                                    req_last_dim,
   output dim_cmd_type                                  dcmd,
   output logic      [$clog2(MAX_MATRICES + 1)-1:0]     dim_wr_addr,
   output logic      [DIM_W-1:0]                        dim_wr_data,
   output logic      [$clog2(MAX_MATRICES + 1)-1:0]     dim_rd_a_addr,
   output logic      [$clog2(MAX_MATRICES + 1)-1:0]     dim_rd_b_addr,
   output step_cmd_type                                 scmd,
   output logic      [$clog2(MAX_MATRICES)-1:0]         i0,
   output logic      [$clog2(MAX_MATRICES)-1:0]         j0,
   output logic      [$clog2(MAX_MATRICES)-1:0]         k0,
   input  wire logic                                    cell_done,
   input  wire logic [COST_W-1:0]                       best_cost,
   input  wire logic [$clog2(MAX_MATRICES)-1:0]         best_k,
   output logic                                         rsp_valid,
   output logic      [COST_W-1:0]                       rsp_min_cost,
   output logic      [OUT_IDX_W-1:0]                    rsp_top_split,
   output logic      [OUT_IDX_W-1:0]                    rsp_chain_length,
   output logic                                         rsp_error_flag
);

   localparam int unsigned DIM_DEPTH = MAX_MATRICES + 1;
   localparam int unsigned DIM_AW = $clog2(DIM_DEPTH);
   localparam int unsigned CNT_W = $clog2(DIM_DEPTH + 1);
   localparam int unsigned IDX_W = $clog2(MAX_MATRICES);

   state_type             state_ff;
   state_type             state_in;
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  ovf_ff;
   logic                  ovf_in;
   logic [IDX_W-1:0]      i0_ff;
   logic [IDX_W-1:0]      i0_in;
   logic [IDX_W-1:0]      j0_ff;
   logic [IDX_W-1:0]      j0_in;
   logic [IDX_W-1:0]      k0_ff;
   logic [IDX_W-1:0]      k0_in;
   logic [IDX_W-1:0]      nm1_ff;
   logic [IDX_W-1:0]      nm1_in;
   logic [COST_W-1:0]     res_cost_ff;
   logic [COST_W-1:0]     res_cost_in;
   logic [OUT_IDX_W-1:0]  res_split_ff;
   logic [OUT_IDX_W-1:0]  res_split_in;
   logic [OUT_IDX_W-1:0]  res_len_ff;
   logic [OUT_IDX_W-1:0]  res_len_in;
   logic                  res_err_ff;
   logic                  res_err_in;

   logic                  accept;
   logic                  have_room;
   logic [CNT_W-1:0]      count_acc;
   logic                  ovf_acc;
   logic                  bad_chain;
   logic                  single;
   logic                  last_split;
   logic                  final_cell;
   logic [IDX_W-1:0]      k_next;

   assign accept     = start & (state_ff == ST_LOAD);
   assign have_room  = (count_ff < CNT_W'(DIM_DEPTH));
   assign count_acc  = count_ff + CNT_W'(have_room);
   assign ovf_acc    = ovf_ff | ~have_room;
   assign bad_chain  = ovf_acc | (count_acc < CNT_W'(2));
   assign single     = (count_acc == CNT_W'(2));
   assign k_next     = k0_ff + IDX_W'(1);
   assign last_split = (k_next == j0_ff);
   assign final_cell = (i0_ff == '0) && (j0_ff == nm1_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept && req_last_dim) begin
               state_in = (bad_chain || single) ? ST_RESP : ST_INIT;
            end
         end
         ST_INIT: begin
            state_in = ST_STEP;
         end
         ST_STEP: begin
            if (last_split) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (cell_done) begin
               state_in = final_cell ? ST_RESP : ST_INIT;
            end
         end
         ST_RESP: begin
            state_in = ST_LOAD;
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_comb begin
      dcmd         = '0;
      scmd         = '0;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i0_in        = i0_ff;
      j0_in        = j0_ff;
      k0_in        = k0_ff;
      nm1_in       = nm1_ff;
      res_cost_in  = res_cost_ff;
      res_split_in = res_split_ff;
      res_len_in   = res_len_ff;
      res_err_in   = res_err_ff;
      case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               dcmd.wr_en = have_room;
               count_in   = count_acc;
               ovf_in     = ovf_acc;
               if (req_last_dim) begin
                  count_in     = '0;
                  ovf_in       = 1'b0;
                  res_cost_in  = '0;
                  res_split_in = '0;
                  res_err_in   = bad_chain;
                  res_len_in   = bad_chain ? '0 : OUT_IDX_W'(count_acc - CNT_W'(1));
                  nm1_in       = IDX_W'(count_acc - CNT_W'(2));
                  i0_in        = '0;
                  j0_in        = IDX_W'(1);
               end
            end
         end
         ST_INIT: begin
            dcmd.rd_ends = 1'b1;
            scmd.init    = 1'b1;
            k0_in        = i0_ff;
         end
         ST_STEP: begin
            scmd.issue = 1'b1;
            scmd.last  = last_split;
            k0_in      = k_next;
         end
         ST_DRAIN: begin
            if (cell_done) begin
               if (final_cell) begin
                  res_cost_in  = best_cost;
                  res_split_in = OUT_IDX_W'(best_k);
               end else if (j0_ff == nm1_ff) begin
                  i0_in = '0;
                  j0_in = j0_ff - i0_ff + IDX_W'(1);
               end else begin
                  i0_in = i0_ff + IDX_W'(1);
                  j0_in = j0_ff + IDX_W'(1);
               end
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      i0_ff        <= i0_in;
      j0_ff        <= j0_in;
      k0_ff        <= k0_in;
      nm1_ff       <= nm1_in;
      res_cost_ff  <= res_cost_in;
      res_split_ff <= res_split_in;
      res_len_ff   <= res_len_in;
      res_err_ff   <= res_err_in;
   end

   assign busy          = (state_ff != ST_LOAD);
   assign dim_wr_addr   = count_ff[DIM_AW-1:0];
   assign dim_wr_data   = req_dim_value;
   assign dim_rd_a_addr = (state_ff == ST_INIT) ? DIM_AW'(i0_ff) : DIM_AW'(k_next);
   assign dim_rd_b_addr = DIM_AW'(j0_ff) + DIM_AW'(1);
   assign i0            = i0_ff;
   assign j0            = j0_ff;
   assign k0            = k0_ff;

   assign rsp_valid        = (state_ff == ST_RESP);
   assign rsp_min_cost     = res_cost_ff;
   assign rsp_top_split    = res_split_ff;
   assign rsp_chain_length = res_len_ff;
   assign rsp_error_flag   = res_err_ff;

endmodule

`default_nettype wire

@@ sv/matrix_chain_order_dp_top.sv @@
// Channel    Dir  Ports                                       Beat taken when
// request    in   req_dim_value, req_last_dim                 start && !busy
// response   out  rsp_min_cost, rsp_top_split,                rsp_valid (one cycle)
//                 rsp_chain_length, rsp_error_flag
//
// Dimension beats are taken back to back; busy stays low while a chain is loading.
// After the last beat, each table cell of span len is worked in turn: the outer dimensions
// are read, len - 1 split steps are issued, and the pipeline is drained to write the cell
// back and hand its result to the controller.
// Chains that are too short or too long go straight to the response; reset is synchronous.
// The response cannot be stalled and is shown for exactly one cycle.
`default_nettype none

module matrix_chain_order_dp_top
   import mcodp_pkg::*;
#(
   parameter int unsigned MAX_MATRICES = MAX_MATRICES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [DIM_W-1:0]      req_dim_value,
   input  wire logic                  req_last_dim,
   output logic                       rsp_valid,
   output logic      [COST_W-1:0]     rsp_min_cost,
   output logic      [OUT_IDX_W-1:0]  rsp_top_split,
   output logic      [OUT_IDX_W-1:0]  rsp_chain_length,
   output logic                       rsp_error_flag
);

   localparam int unsigned DIM_AW = $clog2(MAX_MATRICES + 1);
   localparam int unsigned IDX_W = $clog2(MAX_MATRICES);

   dim_cmd_type        dcmd;
   step_cmd_type       scmd;
   logic [DIM_AW-1:0]  dim_wr_addr;
   logic [DIM_W-1:0]   dim_wr_data;
   logic [DIM_AW-1:0]  dim_rd_a_addr;
   logic [DIM_AW-1:0]  dim_rd_b_addr;
   logic [IDX_W-1:0]   i0;
   logic [IDX_W-1:0]   j0;
   logic [IDX_W-1:0]   k0;
   logic [DIM_W-1:0]   pi;
   logic [DIM_W-1:0]   pk;
   logic [DIM_W-1:0]   pj;
   logic               cell_done;
   logic [COST_W-1:0]  best_cost;
   logic [IDX_W-1:0]   best_k;

   mcodp_ctrl #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_dim_value    (req_dim_value),
      .req_last_dim     (req_last_dim),
      .dcmd             (dcmd),
      .dim_wr_addr      (dim_wr_addr),
      .dim_wr_data      (dim_wr_data),
      .dim_rd_a_addr    (dim_rd_a_addr),
      .dim_rd_b_addr    (dim_rd_b_addr),
      .scmd             (scmd),
      .i0               (i0),
      .j0               (j0),
      .k0               (k0),
      .cell_done        (cell_done),
      .best_cost        (best_cost),
      .best_k           (best_k),
      .rsp_valid        (rsp_valid),
      .rsp_min_cost     (rsp_min_cost),
      .rsp_top_split    (rsp_top_split),
      .rsp_chain_length (rsp_chain_length),
      .rsp_error_flag   (rsp_error_flag)
   );

   mcodp_dims #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_dims (
      .clock     (clock),
      .reset     (reset),
      .dcmd      (dcmd),
      .wr_addr   (dim_wr_addr),
      .wr_data   (dim_wr_data),
      .rd_a_addr (dim_rd_a_addr),
      .rd_b_addr (dim_rd_b_addr),
      .pk        (pk),
      .pi        (pi),
      .pj        (pj)
   );

   mcodp_cell #(
      .MAX_MATRICES (MAX_MATRICES)
   ) u_cell (
      .clock     (clock),
      .reset     (reset),
      .scmd      (scmd),
      .i0        (i0),
      .j0        (j0),
      .k0        (k0),
      .pi        (pi),
      .pk        (pk),
      .pj        (pj),
      .done      (cell_done),
      .best_cost (best_cost),
      .best_k    (best_k)
   );

endmodule

`default_nettype wire

@@ sv/mcodp_checker.sv @@
`default_nettype none
`include "matrix_chain_order_dp_top_macros.svh"

module mcodp_checker
   import mcodp_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  req_last_dim,
   input wire logic                  rsp_valid,
   input wire logic [COST_W-1:0]     rsp_min_cost,
   input wire logic [OUT_IDX_W-1:0]  rsp_top_split,
   input wire logic [OUT_IDX_W-1:0]  rsp_chain_length,
   input wire logic                  rsp_error_flag
);

   `MCODP_ASSERT_NOW(a_rsp_while_busy, rsp_valid, busy)
   `MCODP_ASSERT_NEXT(a_idle_after_rsp, rsp_valid, !busy && !rsp_valid)
   `MCODP_ASSERT_NEXT(a_mid_beat_stays_idle, start && !busy && !req_last_dim, !busy)
   `MCODP_ASSERT_NEXT(a_last_beat_goes_busy, start && !busy && req_last_dim, busy)
   `MCODP_ASSERT_NOW(a_error_fields_zero, rsp_valid && rsp_error_flag,
      rsp_min_cost == '0 && rsp_top_split == '0 && rsp_chain_length == '0)

endmodule

bind matrix_chain_order_dp_top mcodp_checker u_checker (.*);

`default_nettype wire
